FILE: rtl/vzre_pkg.sv
// Shared types and codes for the varint and zero-run encoder.
`default_nettype none

package vzre_pkg;

   // Command codes carried on the request tuser field.
   typedef enum logic [1:0] {
      FUNC_RAW   = 2'd0,
      FUNC_U32   = 2'd1,
      FUNC_S64   = 2'd2,
      FUNC_FLUSH = 2'd3
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_RAW,
      ST_VAR,
      ST_ZERO
   } state_type;

   // Source of the next output byte.
   typedef enum logic [1:0] {
      SEL_RUN,
      SEL_RAW,
      SEL_VAR,
      SEL_ZERO
   } emit_sel_type;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned GROUP_W   = 7;
   localparam logic [BYTE_W-1:0] RUN_LIMIT = 8'd255;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
      logic         run_clear;
      logic         run_set_one;
      logic         run_inc;
      logic         shift;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic run_nonzero;
      logic run_full;
      logic in_zero;
      logic var_more;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/varint_zero_run_encoder_unit.sv
// Top level of the varint and zero-run encoder.
//
// Each request transaction is one put command; the block answers with zero to
// eleven response transactions of one byte each, tlast marking the final byte
// of the command. A command is taken only when the controller is idle, then
// its bytes leave one per cycle, while the response side does not stall,
// through a single output register; the most, eleven, come from a signed
// 64-bit value behind a pending zero run. A zero that merely extends a run,
// or a flush with no run pending, produces no byte.
`default_nettype none

module varint_zero_run_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast
);
   import vzre_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Command sequencer.
   vzre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_func    (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Operand, run counter and output register.
   vzre_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_func    (req_tuser),
      .in_value   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/vzre_datapath.sv
// Datapath: operand shift register, zero-run counter and output register.
`default_nettype none

module vzre_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vzre_pkg::cmd_type        cmd,
   output vzre_pkg::status_type          status,
   input  wire logic [1:0]               in_func,
   input  wire logic [63:0]              in_value,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast
);
   import vzre_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] masked;
   logic [BYTE_W-1:0]  run_ff, run_in;
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               more;

   // Operand masked to the bits the command uses.
   always_comb begin
      unique case (func_type'(in_func))
         FUNC_RAW:   masked = {{(VALUE_W-BYTE_W){1'b0}}, in_value[BYTE_W-1:0]};
         FUNC_U32:   masked = {32'd0, in_value[31:0]};
         FUNC_S64:   masked = in_value;
         FUNC_FLUSH: masked = '0;
         default:    masked = '0;
      endcase
   end

   assign more = |value_ff[VALUE_W-1:GROUP_W];

   // Status toward the controller.
   always_comb begin
      status.out_free    = !valid_ff || rsp_tready;
      status.run_nonzero = run_ff != '0;
      status.run_full    = run_ff == RUN_LIMIT;
      status.in_zero     = masked == '0;
      status.var_more    = more;
   end

   // Operand register: loaded on accept, shifted by one group per varint byte.
   always_comb begin
      value_in = value_ff;
      if (cmd.load) begin
         value_in = masked;
      end else if (cmd.shift) begin
         value_in = value_ff >> GROUP_W;
      end
   end

   // Zero-run counter.
   always_comb begin
      run_in = run_ff;
      if (cmd.run_set_one) begin
         run_in = 8'd1;
      end else if (cmd.run_clear) begin
         run_in = '0;
      end else if (cmd.run_inc) begin
         run_in = run_ff + 8'd1;
      end
   end

   // Output register holds one byte until the transaction completes.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         last_in  = cmd.emit_last;
         unique case (cmd.emit_sel)
            SEL_RUN:  byte_in = run_ff;
            SEL_RAW:  byte_in = value_ff[BYTE_W-1:0];
            SEL_VAR:  byte_in = {more, value_ff[GROUP_W-1:0]};
            SEL_ZERO: byte_in = '0;
            default:  byte_in = '0;
         endcase
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

FILE: rtl/vzre_ctrl.sv
// Controller: sequences the bytes produced by each command.
`default_nettype none

module vzre_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           in_func,
   input  wire vzre_pkg::status_type status,
   output vzre_pkg::cmd_type         cmd
);
   import vzre_pkg::*;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   logic      zero_ff, zero_in;
   logic      accept;
   func_type  func_now;

   assign func_now   = func_type'(in_func);
   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // Command kind and zero flag are kept for the state after the count byte.
   always_comb begin
      func_in = func_ff;
      zero_in = zero_ff;
      if (accept) begin
         func_in = func_now;
         zero_in = status.in_zero;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_now)
                  FUNC_RAW: state_in = status.run_nonzero ? ST_RUN : ST_RAW;
                  FUNC_U32: begin
                     if (status.in_zero) begin
                        priority if (!status.run_nonzero) state_in = ST_ZERO;
                        else if (status.run_full)         state_in = ST_RUN;
                        else                              state_in = ST_IDLE;
                     end else begin
                        state_in = status.run_nonzero ? ST_RUN : ST_VAR;
                     end
                  end
                  FUNC_S64:   state_in = status.run_nonzero ? ST_RUN : ST_VAR;
                  FUNC_FLUSH: state_in = status.run_nonzero ? ST_RUN : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               unique case (func_ff)
                  FUNC_RAW:   state_in = ST_RAW;
                  FUNC_U32:   state_in = zero_ff ? ST_ZERO : ST_VAR;
                  FUNC_S64:   state_in = ST_VAR;
                  FUNC_FLUSH: state_in = ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_VAR: begin
            if (status.out_free && !status.var_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW, ST_ZERO: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.load = accept;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.run_inc = accept && func_now == FUNC_U32 && status.in_zero
                          && status.run_nonzero && !status.run_full;
         end
         ST_RUN: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_RUN;
            cmd.emit_last = func_ff == FUNC_FLUSH;
            cmd.run_clear = status.out_free;
         end
         ST_RAW: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_RAW;
            cmd.emit_last = 1'b1;
         end
         ST_VAR: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_VAR;
            cmd.emit_last = !status.var_more;
            cmd.shift     = status.out_free;
         end
         ST_ZERO: begin
            cmd.emit        = status.out_free;
            cmd.emit_sel    = SEL_ZERO;
            cmd.emit_last   = 1'b1;
            cmd.run_set_one = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      zero_ff <= zero_in;
   end

endmodule

`default_nettype wire
